// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the keyboard translator RTL.
// Used by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define KA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define KA_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- hdl/kbdasc_pkg.sv -----
// Package for the keyboard report to ASCII translator: sizes, key codes,
// key classes, lane and queue types and the key map. No dependencies.
package kbdasc_pkg;

  localparam int Ports         = 4;
  localparam int KeysPerReport = 3;
  localparam int InKeys        = 3;
  localparam int MaxOut        = 9;
  localparam int PortIdxW      = (Ports > 1) ? $clog2(Ports) : 1;
  localparam int CntW          = $clog2(MaxOut + 1);
  localparam int IdxW          = (MaxOut > 1) ? $clog2(MaxOut) : 1;

  typedef enum logic [1:0] {
    OpReport  = 2'd0,
    OpClear   = 2'd1,
    OpLoadLed = 2'd2
  } opcode_e;

  localparam logic [7:0] LedNum   = 8'h01;
  localparam logic [7:0] LedCaps  = 8'h02;
  localparam logic [7:0] LedPower = 8'h04;

  localparam logic [15:0] CodeCapsLock   = 16'h0f05;
  localparam logic [15:0] CodeNumLock    = 16'h0a05;
  localparam logic [15:0] CodeLeftCtrl   = 16'h1107;
  localparam logic [15:0] CodeLeftShift  = 16'h0e01;
  localparam logic [15:0] CodeRightShift = 16'h0e06;
  localparam logic [15:0] CodeBackspace  = 16'h0d06;
  localparam logic [15:0] CodeDelete     = 16'h1008;
  localparam logic [15:0] CodeRight      = 16'h0405;
  localparam logic [15:0] CodeLeft       = 16'h0205;
  localparam logic [15:0] CodeDown       = 16'h0305;
  localparam logic [15:0] CodeUp         = 16'h0204;

  localparam logic [7:0] CtrlMask = 8'h1f;
  localparam logic [7:0] ChEsc    = 8'h1b;
  localparam logic [7:0] ChBrack  = 8'h5b;
  localparam logic [7:0] ChDel    = 8'h7f;

  typedef enum logic [2:0] {
    KeyNone,
    KeyCaps,
    KeyNum,
    KeyErase,
    KeyArrow,
    KeyMod,
    KeyMap
  } key_class_e;

  typedef struct packed {
    logic       act;
    key_class_e cls;
    logic [7:0] plain;
    logic [7:0] upper;
    logic [7:0] arrow;
    logic       letter;
    logic       shift;
    logic       ctrl;
  } lane_t;

  typedef struct packed {
    logic [7:0] character;
    logic [7:0] led;
  } byte_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] plain;
    logic [7:0] upper;
  } map_t;

  function automatic map_t map_lookup(input logic [15:0] code);
    map_t m;
    m.hit = 1'b1;
    m.plain = 8'h00;
    m.upper = 8'h00;
    case (code)
      16'h0d07: begin m.plain = "a"; m.upper = "A"; end
      16'h0708: begin m.plain = "b"; m.upper = "B"; end
      16'h0508: begin m.plain = "c"; m.upper = "C"; end
      16'h0507: begin m.plain = "d"; m.upper = "D"; end
      16'h0601: begin m.plain = "e"; m.upper = "E"; end
      16'h0607: begin m.plain = "f"; m.upper = "F"; end
      16'h0707: begin m.plain = "g"; m.upper = "G"; end
      16'h0807: begin m.plain = "h"; m.upper = "H"; end
      16'h0804: begin m.plain = "i"; m.upper = "I"; end
      16'h0907: begin m.plain = "j"; m.upper = "J"; end
      16'h0903: begin m.plain = "k"; m.upper = "K"; end
      16'h0803: begin m.plain = "l"; m.upper = "L"; end
      16'h0908: begin m.plain = "m"; m.upper = "M"; end
      16'h0808: begin m.plain = "n"; m.upper = "N"; end
      16'h0704: begin m.plain = "o"; m.upper = "O"; end
      16'h0604: begin m.plain = "p"; m.upper = "P"; end
      16'h0c01: begin m.plain = "q"; m.upper = "Q"; end
      16'h0701: begin m.plain = "r"; m.upper = "R"; end
      16'h0c07: begin m.plain = "s"; m.upper = "S"; end
      16'h0801: begin m.plain = "t"; m.upper = "T"; end
      16'h0904: begin m.plain = "u"; m.upper = "U"; end
      16'h0608: begin m.plain = "v"; m.upper = "V"; end
      16'h0501: begin m.plain = "w"; m.upper = "W"; end
      16'h0c08: begin m.plain = "x"; m.upper = "X"; end
      16'h0901: begin m.plain = "y"; m.upper = "Y"; end
      16'h0d08: begin m.plain = "z"; m.upper = "Z"; end
      16'h0c05: begin m.plain = "1"; m.upper = "!"; end
      16'h0505: begin m.plain = "2"; m.upper = "@"; end
      16'h0605: begin m.plain = "3"; m.upper = "#"; end
      16'h0705: begin m.plain = "4"; m.upper = "$"; end
      16'h0805: begin m.plain = "5"; m.upper = "%"; end
      16'h0905: begin m.plain = "6"; m.upper = "^"; end
      16'h0906: begin m.plain = "7"; m.upper = "&"; end
      16'h0806: begin m.plain = "8"; m.upper = "*"; end
      16'h0706: begin m.plain = "9"; m.upper = "("; end
      16'h0606: begin m.plain = "0"; m.upper = ")"; end
      16'h0d04: begin m.plain = 8'h0d; m.upper = 8'h0d; end
      16'h0a08: begin m.plain = 8'h1b; m.upper = 8'h1b; end
      16'h0d01: begin m.plain = 8'h09; m.upper = 8'h09; end
      16'h0602: begin m.plain = " "; m.upper = " "; end
      16'h1004: begin m.plain = "-"; m.upper = "_"; end
      16'h0c04: begin m.plain = "["; m.upper = "{"; end
      16'h0406: begin m.plain = "]"; m.upper = "}"; end
      16'h1105: begin m.plain = ";"; m.upper = ":"; end
      16'h0504: begin m.plain = 8'h27; m.upper = 8'h22; end
      16'h0902: begin m.plain = ","; m.upper = "<"; end
      16'h0802: begin m.plain = "."; m.upper = ">"; end
      16'h0702: begin m.plain = "/"; m.upper = "?"; end
      16'h0603: begin m.plain = "*"; m.upper = "*"; end
      16'h0506: begin m.plain = "-"; m.upper = "-"; end
      16'h0c06: begin m.plain = "+"; m.upper = "+"; end
      16'h1002: begin m.plain = "1"; m.upper = "1"; end
      16'h0e02: begin m.plain = "2"; m.upper = "2"; end
      16'h1006: begin m.plain = "3"; m.upper = "3"; end
      default:  m.hit = 1'b0;
    endcase
    return m;
  endfunction

endpackage

// ----- hdl/kbdasc_if.sv -----
// Valid/ready channel interfaces for the keyboard translator: report input
// and console byte output. Depends on nothing.
interface kbdasc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [1:0]  port;
  logic [15:0] key_first;
  logic [15:0] key_second;
  logic [15:0] key_third;
  logic [7:0]  led_value;

  modport source (output valid, opcode, port, key_first, key_second, key_third, led_value,
                  input ready);
  modport sink (input valid, opcode, port, key_first, key_second, key_third, led_value,
                output ready);
endinterface

interface kbdasc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;
  logic [7:0] led_state;

  modport source (output valid, character, last, led_state, input ready);
  modport sink (input valid, character, last, led_state, output ready);
endinterface

// ----- hdl/kbdasc_lane.sv -----
// One key lane: new-press detection against the port history and key
// classification. Depends on kbdasc_pkg.
module kbdasc_lane (
  input  logic [15:0]         code_i,
  input  logic [15:0]         prev_i [kbdasc_pkg::KeysPerReport],
  output kbdasc_pkg::lane_t   lane_o
);

  always_comb begin
    logic seen;
    kbdasc_pkg::map_t m;
    seen = 1'b0;
    for (int k = 0; k < kbdasc_pkg::KeysPerReport; k++) begin
      if (prev_i[k] == code_i) seen = 1'b1;
    end
    m = kbdasc_pkg::map_lookup(code_i);

    lane_o.act    = (code_i != 16'h0000) && !seen;
    lane_o.plain  = m.plain;
    lane_o.upper  = m.upper;
    lane_o.letter = m.hit && (m.plain >= "a") && (m.plain <= "z");
    lane_o.shift  = (code_i == kbdasc_pkg::CodeLeftShift) ||
                    (code_i == kbdasc_pkg::CodeRightShift);
    lane_o.ctrl   = (code_i == kbdasc_pkg::CodeLeftCtrl);

    unique case (code_i) inside
      kbdasc_pkg::CodeCapsLock: lane_o.cls = kbdasc_pkg::KeyCaps;
      kbdasc_pkg::CodeNumLock:  lane_o.cls = kbdasc_pkg::KeyNum;
      kbdasc_pkg::CodeBackspace, kbdasc_pkg::CodeDelete:
        lane_o.cls = kbdasc_pkg::KeyErase;
      kbdasc_pkg::CodeRight, kbdasc_pkg::CodeLeft, kbdasc_pkg::CodeDown, kbdasc_pkg::CodeUp:
        lane_o.cls = kbdasc_pkg::KeyArrow;
      kbdasc_pkg::CodeLeftCtrl, kbdasc_pkg::CodeLeftShift, kbdasc_pkg::CodeRightShift:
        lane_o.cls = kbdasc_pkg::KeyMod;
      default:
        lane_o.cls = m.hit ? kbdasc_pkg::KeyMap : kbdasc_pkg::KeyNone;
    endcase

    unique case (code_i)
      kbdasc_pkg::CodeRight: lane_o.arrow = "C";
      kbdasc_pkg::CodeLeft:  lane_o.arrow = "D";
      kbdasc_pkg::CodeDown:  lane_o.arrow = "B";
      default:               lane_o.arrow = "A";
    endcase
  end

endmodule

// ----- hdl/kbdasc_merge.sv -----
// Merge stage: walks the lanes in report order, applies lock toggles and
// case rules, and packs the emitted bytes. Depends on kbdasc_pkg.
module kbdasc_merge (
  input  kbdasc_pkg::lane_t         lanes_i [kbdasc_pkg::KeysPerReport],
  input  logic [7:0]                led_i,
  output kbdasc_pkg::byte_t         ent_o [kbdasc_pkg::MaxOut],
  output logic [kbdasc_pkg::CntW-1:0] cnt_o,
  output logic [7:0]                led_o
);

  always_comb begin
    logic       shift;
    logic       ctrl;
    logic [7:0] led;
    logic [7:0] ch;
    logic [7:0] b [3];
    logic [1:0] n;
    logic [kbdasc_pkg::CntW-1:0] cnt;

    shift = 1'b0;
    ctrl  = 1'b0;
    ch    = 8'h00;
    for (int k = 0; k < kbdasc_pkg::KeysPerReport; k++) begin
      shift = shift | lanes_i[k].shift;
      ctrl  = ctrl | lanes_i[k].ctrl;
    end

    led = led_i;
    cnt = '0;
    for (int i = 0; i < kbdasc_pkg::MaxOut; i++) ent_o[i] = '0;

    for (int k = 0; k < kbdasc_pkg::KeysPerReport; k++) begin
      n = 2'd0;
      b[0] = kbdasc_pkg::ChEsc;
      b[1] = kbdasc_pkg::ChBrack;
      b[2] = lanes_i[k].arrow;
      if (lanes_i[k].act) begin
        case (lanes_i[k].cls)
          kbdasc_pkg::KeyCaps:  led = led ^ kbdasc_pkg::LedCaps;
          kbdasc_pkg::KeyNum:   led = led ^ kbdasc_pkg::LedNum;
          kbdasc_pkg::KeyErase: begin
            n = 2'd1;
            b[0] = kbdasc_pkg::ChDel;
          end
          kbdasc_pkg::KeyArrow: n = 2'd3;
          kbdasc_pkg::KeyMap: begin
            ch = lanes_i[k].plain;
            if (lanes_i[k].letter) begin
              if (shift != ((led & kbdasc_pkg::LedCaps) != 8'h00)) ch = lanes_i[k].upper;
              if (ctrl) ch = ch & kbdasc_pkg::CtrlMask;
            end else if (shift) begin
              ch = lanes_i[k].upper;
            end
            n = 2'd1;
            b[0] = ch;
          end
          default: n = 2'd0;
        endcase
      end
      for (int j = 0; j < 3; j++) begin
        if ((j < int'(n)) && (int'(cnt) < kbdasc_pkg::MaxOut)) begin
          ent_o[cnt[kbdasc_pkg::IdxW-1:0]].character = b[j];
          ent_o[cnt[kbdasc_pkg::IdxW-1:0]].led       = led;
          cnt = cnt + 1'b1;
        end
      end
    end

    cnt_o = cnt;
    led_o = led;
  end

endmodule

// ----- hdl/kbdasc_outbuf.sv -----
// Output buffer: one pending report bundle plus a draining shift queue that
// sends one byte per transaction. Depends on kbdasc_pkg, kbdasc_if, macros.
`include "assert_macros.svh"

module kbdasc_outbuf (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  kbdasc_pkg::byte_t           ent_i [kbdasc_pkg::MaxOut],
  input  logic [kbdasc_pkg::CntW-1:0] cnt_i,
  output logic                        ready_o,
  kbdasc_out_if.source                out_o
);

  kbdasc_pkg::byte_t           pend_q [kbdasc_pkg::MaxOut];
  kbdasc_pkg::byte_t           ent_q [kbdasc_pkg::MaxOut];
  logic [kbdasc_pkg::CntW-1:0] pend_cnt_q;
  logic [kbdasc_pkg::CntW-1:0] cnt_q, cnt_d;
  logic                        pend_v_q, pend_v_d;
  logic                        take;
  logic                        free;
  logic                        move;

  assign take    = out_o.valid && out_o.ready;
  assign free    = (cnt_q == '0) || ((cnt_q == kbdasc_pkg::CntW'(1)) && take);
  assign move    = pend_v_q && free;
  assign ready_o = !pend_v_q || free;

  assign out_o.valid     = (cnt_q != '0);
  assign out_o.character = ent_q[0].character;
  assign out_o.led_state = ent_q[0].led;
  assign out_o.last      = (cnt_q == kbdasc_pkg::CntW'(1));

  always_comb begin
    pend_v_d = pend_v_q;
    if (load_i) begin
      pend_v_d = 1'b1;
    end else if (move) begin
      pend_v_d = 1'b0;
    end
    cnt_d = cnt_q;
    if (move) begin
      cnt_d = pend_cnt_q;
    end else if (take) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      pend_v_q <= pend_v_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pend_q     <= ent_i;
      pend_cnt_q <= cnt_i;
    end
    if (move) begin
      ent_q <= pend_q;
    end else if (take) begin
      for (int i = 0; i < kbdasc_pkg::MaxOut - 1; i++) ent_q[i] <= ent_q[i + 1];
    end
  end

  `KA_ASSERT(a_load_room, clk_i, rst_ni, load_i |-> (!pend_v_q || free), "load into full buffer")
  `KA_ASSERT(a_pend_nonempty, clk_i, rst_ni, pend_v_q |-> (pend_cnt_q != '0), "empty bundle pending")
  `KA_ASSERT(a_move_count, clk_i, rst_ni, move |=> (cnt_q == $past(pend_cnt_q)), "bundle count lost")
  `KA_NEVER(a_cnt_range, clk_i, rst_ni, int'(cnt_q) > kbdasc_pkg::MaxOut, "byte count overflow")

endmodule

// ----- hdl/keyboard_report_to_ascii_core.sv -----
// Keyboard report to ASCII translator, top level.
// Depends on kbdasc_pkg, kbdasc_if, kbdasc_lane, kbdasc_merge, kbdasc_outbuf.
//
// Usage:
//   in_i carries one transaction per item: opcode, port, three key codes and
//   an LED byte. Key reports update the port's key history and LED byte in
//   the cycle they are accepted, so items may follow back to back on any port.
//   out_o carries one console byte per transaction with the port's LED byte;
//   last marks the final byte of a report. Reports that emit nothing, history
//   clears and LED loads give no output transaction.
// Path: a bundle is registered in the pending slot, then in the shift queue.
// Throughput: one output byte per cycle while out_o.ready is high; a report
//   emits at most 9 bytes. One report bundle waits in a pending slot while
//   the previous one drains, so in_i stays ready until both are occupied;
//   an item that emits nothing never takes the pending slot.
// Reset: LED bytes return to the power bit, key histories clear, and all
//   buffered bytes are dropped.
// Stall: while out_o.ready is low, the current byte holds; in_i.ready drops
//   once the pending slot is full.
module keyboard_report_to_ascii_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  kbdasc_in_if.sink    in_i,
  kbdasc_out_if.source out_o
);

  logic [7:0]  led_q [kbdasc_pkg::Ports];
  logic [15:0] prev_q [kbdasc_pkg::Ports][kbdasc_pkg::KeysPerReport];
  logic [15:0] keys [kbdasc_pkg::KeysPerReport];
  logic [kbdasc_pkg::PortIdxW-1:0] pidx;
  logic        port_ok;
  logic        accept;
  logic        is_report;
  logic        buf_ready;
  logic        load;

  kbdasc_pkg::lane_t           lanes [kbdasc_pkg::KeysPerReport];
  kbdasc_pkg::byte_t           ents [kbdasc_pkg::MaxOut];
  logic [kbdasc_pkg::CntW-1:0] cnt;
  logic [7:0]                  led_new;

  assign pidx      = kbdasc_pkg::PortIdxW'(in_i.port);
  assign port_ok   = (int'(in_i.port) < kbdasc_pkg::Ports);
  assign in_i.ready = buf_ready;
  assign accept    = in_i.valid && in_i.ready;
  assign is_report = (in_i.opcode == kbdasc_pkg::OpReport);
  assign load      = accept && port_ok && is_report && (cnt != '0);

  always_comb begin
    for (int k = 0; k < kbdasc_pkg::KeysPerReport; k++) begin
      case (k)
        0:       keys[k] = in_i.key_first;
        1:       keys[k] = in_i.key_second;
        2:       keys[k] = in_i.key_third;
        default: keys[k] = 16'h0000;
      endcase
    end
  end

  for (genvar g = 0; g < kbdasc_pkg::KeysPerReport; g++) begin : g_lane
    kbdasc_lane u_lane (
      .code_i (keys[g]),
      .prev_i (prev_q[pidx]),
      .lane_o (lanes[g])
    );
  end

  kbdasc_merge u_merge (
    .lanes_i (lanes),
    .led_i   (led_q[pidx]),
    .ent_o   (ents),
    .cnt_o   (cnt),
    .led_o   (led_new)
  );

  kbdasc_outbuf u_outbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .ent_i   (ents),
    .cnt_i   (cnt),
    .ready_o (buf_ready),
    .out_o   (out_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < kbdasc_pkg::Ports; p++) begin
        led_q[p] <= kbdasc_pkg::LedPower;
        for (int k = 0; k < kbdasc_pkg::KeysPerReport; k++) prev_q[p][k] <= 16'h0000;
      end
    end else if (accept && port_ok) begin
      unique case (kbdasc_pkg::opcode_e'(in_i.opcode))
        kbdasc_pkg::OpReport: begin
          led_q[pidx] <= led_new;
          for (int k = 0; k < kbdasc_pkg::KeysPerReport; k++) prev_q[pidx][k] <= keys[k];
        end
        kbdasc_pkg::OpClear: begin
          for (int k = 0; k < kbdasc_pkg::KeysPerReport; k++) prev_q[pidx][k] <= 16'h0000;
        end
        kbdasc_pkg::OpLoadLed: led_q[pidx] <= in_i.led_value;
        default: ;
      endcase
    end
  end

endmodule
